[design/cfrt_pkg.sv]
// Shared constants and codes for the clock frame replacement table.
// Holds table sizing, operation codes and result status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfrt_pkg;

  // Table sizing
  localparam int unsigned FRAMES  = 64;
  localparam int unsigned IDX_W   = $clog2(FRAMES);
  localparam int unsigned STEP_W  = $clog2(2 * FRAMES);
  localparam int unsigned FRAME_W = 20;
  localparam int unsigned PAGE_W  = 20;

  // Operation codes
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_PIN    = 3'd1,
    OP_UNPIN  = 3'd2,
    OP_LOOKUP = 3'd3,
    OP_EVICT  = 3'd4,
    OP_ACCESS = 3'd5
  } op_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK             = 3'd0,
    ST_NOT_FOUND      = 3'd1,
    ST_EMPTY          = 3'd2,
    ST_NONE_EVICTABLE = 3'd3,
    ST_FULL           = 3'd4
  } status_e;

endpackage

`default_nettype wire

[design/clock_frame_replacement_table.sv]
// Clock (second-chance) frame replacement table, top level.
// Depends on cfrt_pkg for sizing, operation and status codes.
//
// Usage: one request enters on the input channel (in_valid_i / in_stall_o)
// and yields exactly one result on the output channel (out_valid_o /
// out_stall_i). A channel moves a request at a clock edge where valid is
// high and stall is low.
// Operation: a small sequencer walks the slots one per cycle through a
// single compare unit and a registered read of the frame/page store.
// Insert, pin, unpin, lookup and access scan from slot 0 to a hit or the
// last slot; evict scans from the clock hand to a victim or for at most
// 2*FRAMES slots; an evict on an empty table or an unknown op skips the
// scan. One request is in work at a time; in_stall_o stays high until its
// result moves to the output register, so a request can be taken while the previous result waits.
// Reset clears all slot marks and the clock hand; frame and page storage
// is not cleared and is only read for valid slots.
// When the receiver stalls, the result holds on the output ports and a
// finished result behind it waits in the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module clock_frame_replacement_table (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [2:0]                      op_i,
  input  wire logic [cfrt_pkg::FRAME_W-1:0]    frame_number_i,
  input  wire logic [cfrt_pkg::PAGE_W-1:0]     page_number_i,
  input  wire logic                            file_backed_i,
  input  wire logic                            is_write_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [2:0]                           status_o,
  output logic [cfrt_pkg::FRAME_W-1:0]         result_frame_o,
  output logic [cfrt_pkg::PAGE_W-1:0]          result_page_o,
  output logic                                 needs_swap_out_o
);
  import cfrt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  // Control state
  state_e              state_q, state_d;
  logic [2:0]          op_q, op_d;
  logic [FRAME_W-1:0]  frame_q, frame_d;
  logic [PAGE_W-1:0]   page_q, page_d;
  logic                fb_q, fb_d;
  logic                wr_q, wr_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [IDX_W-1:0]    hand_q, hand_d;

  // Slot marks
  logic [FRAMES-1:0]   valid_q, valid_d;
  logic [FRAMES-1:0]   pinned_q, pinned_d;
  logic [FRAMES-1:0]   accessed_q, accessed_d;
  logic [FRAMES-1:0]   dirty_q, dirty_d;

  // Pending result
  status_e             res_status_q, res_status_d;
  logic [FRAME_W-1:0]  res_frame_q, res_frame_d;
  logic [PAGE_W-1:0]   res_page_q, res_page_d;
  logic                res_swap_q, res_swap_d;

  // Output register
  logic                out_valid_q, out_valid_d;
  logic [2:0]          out_status_q, out_status_d;
  logic [FRAME_W-1:0]  out_frame_q, out_frame_d;
  logic [PAGE_W-1:0]   out_page_q, out_page_d;
  logic                out_swap_q, out_swap_d;

  // Frame/page store with registered read at the next scan index
  logic [FRAME_W-1:0]  frame_mem [FRAMES];
  logic [PAGE_W-1:0]   page_mem [FRAMES];
  logic                fb_mem [FRAMES];
  logic [FRAME_W-1:0]  rd_frame_q;
  logic [PAGE_W-1:0]   rd_page_q;
  logic                rd_fb_q;
  logic                mem_we;

  logic                last_idx;
  logic                last_step;
  logic [IDX_W-1:0]    idx_nx;
  logic                frame_hit;
  logic                page_hit;
  logic                cand;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[idx_q] <= frame_q;
      page_mem[idx_q]  <= page_q;
      fb_mem[idx_q]    <= fb_q;
    end
    rd_frame_q <= frame_mem[idx_d];
    rd_page_q  <= page_mem[idx_d];
    rd_fb_q    <= fb_mem[idx_d];
  end

  // Shared slot compare for the slot under the index
  always_comb begin
    last_idx  = (idx_q == IDX_W'(FRAMES - 1));
    last_step = (step_q == STEP_W'(2 * FRAMES - 1));
    idx_nx    = last_idx ? '0 : idx_q + 1'b1;
    frame_hit = valid_q[idx_q] && (rd_frame_q == frame_q);
    page_hit  = valid_q[idx_q] && (rd_page_q == page_q);
    cand      = valid_q[idx_q] && !pinned_q[idx_q];
  end

  // Sequencer next state
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    frame_d      = frame_q;
    page_d       = page_q;
    fb_d         = fb_q;
    wr_d         = wr_q;
    idx_d        = idx_q;
    step_d       = step_q;
    hand_d       = hand_q;
    valid_d      = valid_q;
    pinned_d     = pinned_q;
    accessed_d   = accessed_q;
    dirty_d      = dirty_q;
    res_status_d = res_status_q;
    res_frame_d  = res_frame_q;
    res_page_d   = res_page_q;
    res_swap_d   = res_swap_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_frame_d  = out_frame_q;
    out_page_d   = out_page_q;
    out_swap_d   = out_swap_q;
    mem_we       = 1'b0;

    // Drop the output once the receiver takes it
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d         = op_i;
          frame_d      = frame_number_i;
          page_d       = page_number_i;
          fb_d         = file_backed_i;
          wr_d         = is_write_i;
          step_d       = '0;
          idx_d        = '0;
          res_status_d = ST_OK;
          res_frame_d  = '0;
          res_page_d   = '0;
          res_swap_d   = 1'b0;
          case (op_i)
            OP_INSERT, OP_PIN, OP_UNPIN, OP_LOOKUP, OP_ACCESS: begin
              state_d = S_SCAN;
            end
            OP_EVICT: begin
              if (!(|valid_q)) begin
                res_status_d = ST_EMPTY;
                state_d      = S_DONE;
              end else begin
                idx_d   = hand_q;
                state_d = S_SCAN;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Advance one slot on every scan step, also on the step that finishes the request
        idx_d  = idx_nx;
        step_d = step_q + 1'b1;
        case (op_q)
          OP_INSERT: begin
            if (!valid_q[idx_q]) begin
              mem_we               = 1'b1;
              valid_d[idx_q]       = 1'b1;
              pinned_d[idx_q]      = 1'b0;
              accessed_d[idx_q]    = 1'b0;
              dirty_d[idx_q]       = 1'b0;
              state_d              = S_DONE;
            end else if (last_idx) begin
              res_status_d = ST_FULL;
              state_d      = S_DONE;
            end
          end
          OP_PIN, OP_UNPIN: begin
            if (frame_hit) begin
              pinned_d[idx_q] = (op_q == OP_PIN);
              state_d         = S_DONE;
            end else if (last_idx) begin
              res_status_d = ST_NOT_FOUND;
              state_d      = S_DONE;
            end
          end
          OP_LOOKUP: begin
            if (page_hit) begin
              res_frame_d = rd_frame_q;
              state_d     = S_DONE;
            end else if (last_idx) begin
              res_status_d = ST_NOT_FOUND;
              state_d      = S_DONE;
            end
          end
          OP_ACCESS: begin
            if (page_hit) begin
              accessed_d[idx_q] = 1'b1;
              if (wr_q) begin
                dirty_d[idx_q] = 1'b1;
              end
              state_d = S_DONE;
            end else if (last_idx) begin
              res_status_d = ST_NOT_FOUND;
              state_d      = S_DONE;
            end
          end
          OP_EVICT: begin
            if (cand && !accessed_q[idx_q]) begin
              // Free the victim and move the hand past it
              res_frame_d       = rd_frame_q;
              res_page_d        = rd_page_q;
              res_swap_d        = !rd_fb_q || dirty_q[idx_q];
              valid_d[idx_q]    = 1'b0;
              pinned_d[idx_q]   = 1'b0;
              accessed_d[idx_q] = 1'b0;
              dirty_d[idx_q]    = 1'b0;
              hand_d            = idx_nx;
              state_d           = S_DONE;
            end else begin
              // Give a second chance; after two full turns the scan gives up and the hand stays put
              if (cand) begin
                accessed_d[idx_q] = 1'b0;
              end
              if (last_step) begin
                res_status_d = ST_NONE_EVICTABLE;
                state_d      = S_DONE;
              end
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_DONE: begin
        // Move the result into the output register once it is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_frame_d  = res_frame_q;
          out_page_d   = res_page_q;
          out_swap_d   = res_swap_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state, marks, request payload and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      step_q       <= '0;
      hand_q       <= '0;
      valid_q      <= '0;
      pinned_q     <= '0;
      accessed_q   <= '0;
      dirty_q      <= '0;
      out_valid_q  <= 1'b0;
      op_q         <= OP_INSERT;
      frame_q      <= '0;
      page_q       <= '0;
      fb_q         <= 1'b0;
      wr_q         <= 1'b0;
      res_status_q <= ST_OK;
      res_frame_q  <= '0;
      res_page_q   <= '0;
      res_swap_q   <= 1'b0;
      out_status_q <= ST_OK;
      out_frame_q  <= '0;
      out_page_q   <= '0;
      out_swap_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      step_q       <= step_d;
      hand_q       <= hand_d;
      valid_q      <= valid_d;
      pinned_q     <= pinned_d;
      accessed_q   <= accessed_d;
      dirty_q      <= dirty_d;
      out_valid_q  <= out_valid_d;
      op_q         <= op_d;
      frame_q      <= frame_d;
      page_q       <= page_d;
      fb_q         <= fb_d;
      wr_q         <= wr_d;
      res_status_q <= res_status_d;
      res_frame_q  <= res_frame_d;
      res_page_q   <= res_page_d;
      res_swap_q   <= res_swap_d;
      out_status_q <= out_status_d;
      out_frame_q  <= out_frame_d;
      out_page_q   <= out_page_d;
      out_swap_q   <= out_swap_d;
    end
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign result_frame_o   = out_frame_q;
  assign result_page_o    = out_page_q;
  assign needs_swap_out_o = out_swap_q;

  // A taken request always blocks the input on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not blocked after taking a request");

  // A result leaving the sequencer lands in the output register
  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && (!out_valid_q || !out_stall_i) |=> out_valid_o && !in_stall_o)
    else $error("finished result did not reach the output");

  // The clock hand stays inside the table
  a_hand_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hand_q <= IDX_W'(FRAMES - 1))
    else $error("clock hand out of range");

  // A failed eviction leaves the hand where it started
  a_evict_fail_hand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && (op_q == OP_EVICT) && last_step && !(cand && !accessed_q[idx_q])
    |=> $stable(hand_q))
    else $error("hand moved on a failed eviction");

endmodule

`default_nettype wire
